>>> design/bhdc_pkg.sv
// ----------------------------------------------------------------------------
// bhdc_pkg
// Shared types and constants for the button hold-duration classifier.
// ----------------------------------------------------------------------------
package bhdc_pkg;

  localparam int CFG_W  = 16;
  localparam int ADDR_W = 3;

  // request opcodes
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_READ = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;

  // register indexes
  localparam logic [ADDR_W-1:0] REG_DEBOUNCE    = 3'd0;
  localparam logic [ADDR_W-1:0] REG_FIRST_HOLD  = 3'd1;
  localparam logic [ADDR_W-1:0] REG_SECOND_HOLD = 3'd2;
  localparam logic [ADDR_W-1:0] REG_REPEAT      = 3'd3;
  localparam logic [ADDR_W-1:0] REG_PRESS_LOW   = 3'd4;

  // event codes
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_SHORT = 2'd1;
  localparam logic [1:0] EV_LONG  = 2'd2;
  localparam logic [1:0] EV_VLONG = 2'd3;

  // register reset values
  localparam logic [CFG_W-1:0] DEBOUNCE_RST    = 16'd50;
  localparam logic [CFG_W-1:0] FIRST_HOLD_RST  = 16'd3000;
  localparam logic [CFG_W-1:0] SECOND_HOLD_RST = 16'd5000;
  localparam logic [CFG_W-1:0] REPEAT_RST      = 16'd20;
  localparam logic             PRESS_LOW_RST   = 1'b1;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ticks;
    logic [CFG_W-1:0] first_hold_ticks;
    logic [CFG_W-1:0] second_hold_ticks;
    logic [CFG_W-1:0] repeat_ticks;
    logic             press_low;
  } cfg_t;

  typedef struct packed {
    logic [1:0] event_code;
    logic       ready_res;
    logic       notify;
    logic       wake;
  } result_t;

endpackage

>>> design/bhdc_if.sv
// ----------------------------------------------------------------------------
// bhdc_in_if / bhdc_out_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface bhdc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic       pin_level;

  modport source (output valid, output op, output pin_level, input ready);
  modport sink   (input valid, input op, input pin_level, output ready);
endinterface

interface bhdc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_code;
  logic       ready_res;
  logic       notify;
  logic       wake;

  modport source (output valid, output event_code, output ready_res,
                  output notify, output wake, input ready);
  modport sink   (input valid, input event_code, input ready_res,
                  input notify, input wake, output ready);
endinterface

>>> design/bhdc_core.sv
// ----------------------------------------------------------------------------
// bhdc_core
// Debounce timer, hold-level tracker and event/ready flags. Computes the
// result of one request and updates state when the request is taken.
// ----------------------------------------------------------------------------
module bhdc_core #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  bhdc_pkg::cfg_t    cfg,
  input  logic              take,
  input  logic [1:0]        op,
  input  logic              pin_level,
  output bhdc_pkg::result_t res
);

  localparam logic [32:0] TMAX = (33'd1 << TIMER_WIDTH) - 33'd1;

  logic [TIMER_WIDTH-1:0] timer_count, timer_count_next, timer_dec;
  logic                   timer_armed, timer_armed_next;
  logic [1:0]             hold_level, hold_level_next;
  logic [1:0]             event_reg, event_reg_next;
  logic                   ready_flag, ready_flag_next;
  logic                   last_pin, last_pin_next;

  // zero acts as one tick; saturate to the timer range
  function automatic logic [TIMER_WIDTH-1:0] load_value(
    input logic [bhdc_pkg::CFG_W-1:0] d
  );
    logic [32:0] wide;
    wide = 33'(d);
    if (wide > TMAX) wide = TMAX;
    if (wide == 33'd0) wide = 33'd1;
    return wide[TIMER_WIDTH-1:0];
  endfunction

  assign timer_dec = timer_count - {{(TIMER_WIDTH-1){1'b0}}, 1'b1};

  always_comb begin
    timer_count_next = timer_count;
    timer_armed_next = timer_armed;
    hold_level_next  = hold_level;
    event_reg_next   = event_reg;
    ready_flag_next  = ready_flag;
    last_pin_next    = last_pin;
    res.notify       = 1'b0;
    res.wake         = 1'b0;
    res.event_code   = event_reg;
    res.ready_res    = ready_flag;
    case (op)
      bhdc_pkg::OP_TICK: begin
        if (pin_level != last_pin) begin
          last_pin_next    = pin_level;
          timer_count_next = load_value(cfg.debounce_ticks);
          timer_armed_next = 1'b1;
        end else if (timer_armed) begin
          timer_count_next = timer_dec;
          if (timer_dec == '0) begin
            timer_armed_next = 1'b0;
            if ((pin_level ^ cfg.press_low) != 1'b0) begin
              timer_armed_next = 1'b1;
              case (hold_level)
                2'd0: begin
                  hold_level_next  = 2'd1;
                  event_reg_next   = bhdc_pkg::EV_SHORT;
                  res.notify       = 1'b1;
                  timer_count_next = load_value(cfg.first_hold_ticks);
                end
                2'd1: begin
                  hold_level_next  = 2'd2;
                  event_reg_next   = bhdc_pkg::EV_LONG;
                  res.notify       = 1'b1;
                  timer_count_next = load_value(cfg.second_hold_ticks);
                end
                default: begin
                  hold_level_next  = 2'd3;
                  if (event_reg != bhdc_pkg::EV_VLONG) begin
                    event_reg_next = bhdc_pkg::EV_VLONG;
                    res.notify     = 1'b1;
                  end
                  timer_count_next = load_value(cfg.repeat_ticks);
                end
              endcase
            end else begin
              if (hold_level != 2'd0) begin
                ready_flag_next = 1'b1;
                res.wake        = 1'b1;
              end
              hold_level_next = 2'd0;
            end
          end
        end
        res.event_code = event_reg_next;
        res.ready_res  = ready_flag_next;
      end
      bhdc_pkg::OP_READ: begin
        if (ready_flag) begin
          ready_flag_next = 1'b0;
          event_reg_next  = bhdc_pkg::EV_NONE;
        end else begin
          res.event_code  = bhdc_pkg::EV_NONE;
        end
      end
      default: ;  // peek and unused code: report only
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timer_count <= '0;
      timer_armed <= 1'b0;
      hold_level  <= 2'd0;
      event_reg   <= bhdc_pkg::EV_NONE;
      ready_flag  <= 1'b0;
      last_pin    <= bhdc_pkg::PRESS_LOW_RST;
    end else if (take) begin
      timer_count <= timer_count_next;
      timer_armed <= timer_armed_next;
      hold_level  <= hold_level_next;
      event_reg   <= event_reg_next;
      ready_flag  <= ready_flag_next;
      last_pin    <= last_pin_next;
    end
  end

  // an armed timer never holds zero
  assert property (@(posedge clk) disable iff (rst)
    timer_armed |-> timer_count != '0)
    else $error("armed timer at zero");

  // a read with a press pending clears both flags
  assert property (@(posedge clk) disable iff (rst)
    take && op == bhdc_pkg::OP_READ && ready_flag
      |=> !ready_flag && event_reg == bhdc_pkg::EV_NONE)
    else $error("read did not consume press");

  // wake leaves a pending press and the level back at zero
  assert property (@(posedge clk) disable iff (rst)
    take && res.wake |=> ready_flag && hold_level == 2'd0)
    else $error("wake without completed press");

endmodule

>>> design/button_hold_duration_classifier_top.sv
// ----------------------------------------------------------------------------
// button_hold_duration_classifier_top
// Debounced push-button classifier: short press, long hold, very long hold.
// ----------------------------------------------------------------------------
// Each request is a millisecond tick carrying the raw pin level, a read that
// consumes a completed press, or a status peek. One request is taken every
// clock cycle unless a result waits to be taken, and its result is in the
// output register in the next cycle. The cycle time is set by the state
// update path: timer decrement, zero compare and reload select. Registers are
// written through cfg_we / cfg_addr / cfg_wdata; the user must write them
// only while the block is idle, which the block does not enforce; indexes
// above 4 are ignored. There is no memory and no clearing pass after reset.
module button_hold_duration_classifier_top #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bhdc_pkg::ADDR_W-1:0]   cfg_addr,
  input  logic [bhdc_pkg::CFG_W-1:0]    cfg_wdata,
  bhdc_in_if.sink                       in_ch,
  bhdc_out_if.source                    out_ch
);

  bhdc_pkg::cfg_t    cfg;
  bhdc_pkg::result_t res, res_q;
  logic              out_valid;
  logic              take;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks    <= bhdc_pkg::DEBOUNCE_RST;
      cfg.first_hold_ticks  <= bhdc_pkg::FIRST_HOLD_RST;
      cfg.second_hold_ticks <= bhdc_pkg::SECOND_HOLD_RST;
      cfg.repeat_ticks      <= bhdc_pkg::REPEAT_RST;
      cfg.press_low         <= bhdc_pkg::PRESS_LOW_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        bhdc_pkg::REG_DEBOUNCE:    cfg.debounce_ticks    <= cfg_wdata;
        bhdc_pkg::REG_FIRST_HOLD:  cfg.first_hold_ticks  <= cfg_wdata;
        bhdc_pkg::REG_SECOND_HOLD: cfg.second_hold_ticks <= cfg_wdata;
        bhdc_pkg::REG_REPEAT:      cfg.repeat_ticks      <= cfg_wdata;
        bhdc_pkg::REG_PRESS_LOW:   cfg.press_low         <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // take a request whenever the output register is empty or draining
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign take        = in_ch.valid && in_ch.ready;

  bhdc_core #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .take      (take),
    .op        (in_ch.op),
    .pin_level (in_ch.pin_level),
    .res       (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_q <= res;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.event_code = res_q.event_code;
  assign out_ch.ready_res  = res_q.ready_res;
  assign out_ch.notify     = res_q.notify;
  assign out_ch.wake       = res_q.wake;

  // every taken request shows a result in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    take |=> out_ch.valid)
    else $error("taken request produced no result");

  // a stalled result stays put until it is taken
  assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(res_q))
    else $error("stalled result changed");

  // an empty output register never pushes back
  assert property (@(posedge clk) disable iff (rst)
    !out_ch.valid |-> in_ch.ready)
    else $error("request blocked while output empty");

endmodule
